### hdl/b2da_pkg.sv
// b2da_pkg: shared types and constants for the binary to decimal ascii block
// no dependencies; used by b2da_dabble and binary_to_decimal_ascii

package b2da_pkg;

    typedef enum logic [1:0] {
        OP_U8  = 2'd0,
        OP_U16 = 2'd1,
        OP_S16 = 2'd2,
        OP_U32 = 2'd3
    } op_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // decimal digits of each format before clipping to the digit cells
    localparam int DIGITS_U8  = 3;
    localparam int DIGITS_U16 = 5;
    localparam int DIGITS_U32 = 10;

    // binary bits shifted through the converter for each format
    localparam int                   BIT_CNT_W = 6;
    localparam logic [BIT_CNT_W-1:0] BITS_U8   = 6'd8;
    localparam logic [BIT_CNT_W-1:0] BITS_U16  = 6'd16;
    localparam logic [BIT_CNT_W-1:0] BITS_U32  = 6'd32;

    // shift-add-3 correction
    localparam logic [3:0] BCD_FIX_MIN = 4'd5;
    localparam logic [3:0] BCD_FIX_ADD = 4'd3;

endpackage

### hdl/b2da_dabble.sv
// b2da_dabble: one shift-add-3 step over a row of bcd digits
// depends on b2da_pkg for the correction constants

module b2da_dabble #(
    parameter int NDIG = 10
) (
    input  logic [NDIG*4-1:0] bcd_in,
    input  logic              bit_in,
    output logic [NDIG*4-1:0] bcd_out
);

    logic [NDIG*4-1:0] adj;

    // digits of five or more get three added so the shift carries at ten
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_in[i*4 +: 4] >= b2da_pkg::BCD_FIX_MIN)
                adj[i*4 +: 4] = bcd_in[i*4 +: 4] + b2da_pkg::BCD_FIX_ADD;
            else
                adj[i*4 +: 4] = bcd_in[i*4 +: 4];
        end
    end

    // the top digit's carry falls off: value is kept modulo 10^NDIG
    assign bcd_out = {adj[NDIG*4-2:0], bit_in};

endmodule

### hdl/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: top level, fixed-width decimal ascii from a binary word
// depends on b2da_pkg and b2da_dabble
//
// channel  signals                         direction  width
// req      req_valid operation (req_stall out) in         2
//          value                           in         32
// rsp      rsp_valid character (rsp_stall in)  out        8
//          last_char                       out        1
//
// a word is accepted, then converted one binary bit per cycle (8 for u8, 16 for u16
// and s16, 32 for u32) through the shared shift-add-3 step, then emitted at one
// character per cycle unless rsp_stall holds it: 4, 6, 7 or 11 characters with the terminator.
// req_stall is high once a word is accepted until the terminator is loaded in the output register.
// rsp_stall holds the output register and pauses character emission.
// reset clears the sequencer and the output valid; digit cells are not reset.

module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] operation,
    input  logic [31:0] value,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] character,
    output logic       last_char
);

    localparam int BCD_W = MAX_DIGITS * 4;
    localparam int IDX_W = $clog2(MAX_DIGITS);

    localparam logic [IDX_W-1:0] TOP_U8 = IDX_W'(
        ((b2da_pkg::DIGITS_U8 > MAX_DIGITS) ? MAX_DIGITS : b2da_pkg::DIGITS_U8) - 1);
    localparam logic [IDX_W-1:0] TOP_U16 = IDX_W'(
        ((b2da_pkg::DIGITS_U16 > MAX_DIGITS) ? MAX_DIGITS : b2da_pkg::DIGITS_U16) - 1);
    localparam logic [IDX_W-1:0] TOP_U32 = IDX_W'(
        ((b2da_pkg::DIGITS_U32 > MAX_DIGITS) ? MAX_DIGITS : b2da_pkg::DIGITS_U32) - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS,
        ST_TERM
    } state_t;

    state_t                          state_reg, state_next;
    logic [b2da_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]                digit_idx_reg, digit_idx_next;
    logic                            has_sign_reg, has_sign_next;
    logic                            negative_reg, negative_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [7:0]                      character_reg, character_next;
    logic                            last_char_reg, last_char_next;
    logic [31:0]                     work_reg, work_next;
    logic [BCD_W-1:0]                bcd_reg, bcd_next;

    logic [BCD_W-1:0]                bcd_step;
    logic [15:0]                     magnitude;
    logic                            rsp_free;
    logic                            req_take;
    logic [3:0]                      digit_sel;

    b2da_dabble #(
        .NDIG (MAX_DIGITS)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (work_reg[31]),
        .bcd_out (bcd_step)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && (state_reg == ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign magnitude = value[15] ? 16'(~value[15:0] + 16'd1) : value[15:0];
    assign digit_sel = bcd_reg[{digit_idx_reg, 2'b00} +: 4];

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        digit_idx_next = digit_idx_reg;
        has_sign_next  = has_sign_reg;
        negative_next  = negative_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        character_next = character_reg;
        last_char_next = last_char_reg;
        work_next      = work_reg;
        bcd_next       = bcd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next    = ST_CONVERT;
                    bcd_next      = '0;
                    has_sign_next = 1'b0;
                    negative_next = 1'b0;
                    unique case (b2da_pkg::op_t'(operation))
                        b2da_pkg::OP_U8:
                        begin
                            work_next      = {value[7:0], 24'd0};
                            bit_cnt_next   = b2da_pkg::BITS_U8;
                            digit_idx_next = TOP_U8;
                        end
                        b2da_pkg::OP_U16:
                        begin
                            work_next      = {value[15:0], 16'd0};
                            bit_cnt_next   = b2da_pkg::BITS_U16;
                            digit_idx_next = TOP_U16;
                        end
                        b2da_pkg::OP_S16:
                        begin
                            work_next      = {magnitude, 16'd0};
                            bit_cnt_next   = b2da_pkg::BITS_U16;
                            digit_idx_next = TOP_U16;
                            has_sign_next  = 1'b1;
                            negative_next  = value[15];
                        end
                        b2da_pkg::OP_U32:
                        begin
                            work_next      = value;
                            bit_cnt_next   = b2da_pkg::BITS_U32;
                            digit_idx_next = TOP_U32;
                        end
                    endcase
                end
            end
            ST_CONVERT:
            begin
                bcd_next     = bcd_step;
                work_next    = {work_reg[30:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == b2da_pkg::BIT_CNT_W'(1))
                    state_next = has_sign_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    character_next = negative_reg ? b2da_pkg::CHAR_MINUS
                                                  : b2da_pkg::CHAR_PLUS;
                    last_char_next = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    character_next = b2da_pkg::CHAR_ZERO | {4'd0, digit_sel};
                    last_char_next = 1'b0;
                    if (digit_idx_reg == '0)
                        state_next = ST_TERM;
                    else
                        digit_idx_next = digit_idx_reg - 1'b1;
                end
            end
            ST_TERM:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    character_next = b2da_pkg::CHAR_NUL;
                    last_char_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            digit_idx_reg <= '0;
            has_sign_reg  <= 1'b0;
            negative_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            character_reg <= '0;
            last_char_reg <= 1'b0;
            work_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            digit_idx_reg <= digit_idx_next;
            has_sign_reg  <= has_sign_next;
            negative_reg  <= negative_next;
            rsp_valid_reg <= rsp_valid_next;
            character_reg <= character_next;
            last_char_reg <= last_char_next;
            work_reg      <= work_next;
        end
    end

    // digit cells carry no reset
    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign character = character_reg;
    assign last_char = last_char_reg;

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for binary_to_decimal_ascii
// depends on b2da_pkg and the binary_to_decimal_ascii rtl; predicts each ascii string
// and checks every character word against it, with random idling on both channels
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_DIGITS    = 10;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 190;
    localparam int QUIET_WORDS   = 40;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  operation;
    logic [31:0] value;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [7:0]  character;
    logic        last_char;

    char_word_t  expected_chars[$];
    int          error_count;
    int          words_sent;
    int          chars_checked;
    int          op_count[4];
    int          cycle_count;
    int          holds_done;
    bit          quiet;
    bit          hold_request;

    binary_to_decimal_ascii #(
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .character (character),
        .last_char (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // expected string of one word: optional sign, padded digits, terminator
    function automatic void predict_string(input b2da_pkg::op_t op, input logic [31:0] val);
        logic [31:0] work;
        logic [3:0]  digits[MAX_DIGITS];
        int          ndig;
        int          i;
        bit          signed_fmt;
        bit          negative;
        char_word_t  w;
        signed_fmt = 1'b0;
        negative   = 1'b0;
        case (op)
            b2da_pkg::OP_U8:
            begin
                work = {24'd0, val[7:0]};
                ndig = b2da_pkg::DIGITS_U8;
            end
            b2da_pkg::OP_U16:
            begin
                work = {16'd0, val[15:0]};
                ndig = b2da_pkg::DIGITS_U16;
            end
            b2da_pkg::OP_S16:
            begin
                signed_fmt = 1'b1;
                work = {16'd0, val[15:0]};
                // magnitude from 0x10000 so -32768 does not overflow
                if (val[15])
                begin
                    negative = 1'b1;
                    work = 32'h0001_0000 - work;
                end
                ndig = b2da_pkg::DIGITS_U16;
            end
            default:
            begin
                work = val;
                ndig = b2da_pkg::DIGITS_U32;
            end
        endcase
        if (ndig > MAX_DIGITS)
            ndig = MAX_DIGITS;
        for (i = ndig - 1; i >= 0; i--)
        begin
            digits[i] = 4'(work % 10);
            work = work / 10;
        end
        w.last = 1'b0;
        if (signed_fmt)
        begin
            w.ch = negative ? b2da_pkg::CHAR_MINUS : b2da_pkg::CHAR_PLUS;
            expected_chars.push_back(w);
        end
        for (i = 0; i < ndig; i++)
        begin
            w.ch = b2da_pkg::CHAR_ZERO + {4'd0, digits[i]};
            expected_chars.push_back(w);
        end
        w.ch   = b2da_pkg::CHAR_NUL;
        w.last = 1'b1;
        expected_chars.push_back(w);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
            error_count++;
        end
    endtask

    task automatic send_word(input b2da_pkg::op_t op, input logic [31:0] val);
        begin
            @(negedge clk);
            while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
            req_valid <= 1'b1;
            operation <= op;
            value     <= val;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            predict_string(op, val);
            words_sent++;
            op_count[op]++;
        end
    endtask

    // mostly uniform, some near powers of ten for digit carries, some small
    function automatic logic [31:0] random_value();
        logic [31:0] p;
        int          k;
        int          i;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom();
        if (pick < 80)
        begin
            k = $urandom_range(0, 9);
            p = 32'd1;
            for (i = 0; i < k; i++)
                p = p * 10;
            return p + $urandom_range(0, 2) - 1;
        end
        return (32'($urandom_range(0, 255)) << 8) >> $urandom_range(0, 8);
    endfunction

    task automatic test_directed_extremes();
        begin
            send_word(b2da_pkg::OP_U8,  32'h0000_0000);
            send_word(b2da_pkg::OP_U8,  32'h0000_00FF);
            send_word(b2da_pkg::OP_U8,  32'hFFFF_FF00);   // high bits ignored
            send_word(b2da_pkg::OP_U8,  32'h5A5A_A564);
            send_word(b2da_pkg::OP_U16, 32'h0000_0000);
            send_word(b2da_pkg::OP_U16, 32'h0000_FFFF);
            send_word(b2da_pkg::OP_U16, 32'hFFFF_0000);
            send_word(b2da_pkg::OP_U16, 32'h0000_2710);
            send_word(b2da_pkg::OP_S16, 32'h0000_0000);
            send_word(b2da_pkg::OP_S16, 32'h0000_7FFF);
            send_word(b2da_pkg::OP_S16, 32'h0000_8000);   // most negative
            send_word(b2da_pkg::OP_S16, 32'hFFFF_8000);
            send_word(b2da_pkg::OP_S16, 32'h0000_8001);
            send_word(b2da_pkg::OP_S16, 32'h0000_FFFF);
            send_word(b2da_pkg::OP_S16, 32'hABCD_0001);
            send_word(b2da_pkg::OP_U32, 32'h0000_0000);
            send_word(b2da_pkg::OP_U32, 32'hFFFF_FFFF);
            send_word(b2da_pkg::OP_U32, 32'd1_000_000_000);
            send_word(b2da_pkg::OP_U32, 32'd999_999_999);
            send_word(b2da_pkg::OP_U32, 32'h8000_0000);
            send_word(b2da_pkg::OP_U32, 32'h0000_0001);
        end
    endtask

    task automatic test_back_to_back();
        int n;
        begin
            quiet = 1'b1;
            for (n = 0; n < QUIET_WORDS; n++)
                send_word(b2da_pkg::op_t'($urandom_range(0, 3)), random_value());
            quiet = 1'b0;
        end
    endtask

    task automatic test_receiver_holdoff();
        int n;
        begin
            @(posedge clk);
            hold_request = 1'b1;
            for (n = 0; n < 8; n++)
                send_word(b2da_pkg::op_t'($urandom_range(0, 3)), random_value());
        end
    endtask

    task automatic test_random_words();
        int n;
        begin
            for (n = 0; n < RANDOM_WORDS; n++)
                send_word(b2da_pkg::op_t'($urandom_range(0, 3)), random_value());
        end
    endtask

    // receiver: random stall, or one long hold-off on request
    initial
    begin
        int hold_count;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    rsp_stall <= 1'b1;
                    @(negedge clk);
                    hold_count++;
                end
                holds_done++;
            end
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        char_word_t w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("unexpected character word", character, 0);
            else
            begin
                w = expected_chars.pop_front();
                if (character !== w.ch)
                    report_mismatch("character", character, w.ch);
                if (last_char !== w.last)
                    report_mismatch("last_char", last_char, w.last);
                chars_checked++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d character words outstanding",
                 cycle_count, expected_chars.size());
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int drain;
        error_count   = 0;
        words_sent    = 0;
        chars_checked = 0;
        holds_done    = 0;
        op_count      = '{0, 0, 0, 0};
        quiet         = 1'b0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        operation     = b2da_pkg::OP_U8;
        value         = 32'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_back_to_back();
        test_receiver_holdoff();
        test_random_words();

        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);

        $display("sent %0d words (u8 %0d, u16 %0d, s16 %0d, u32 %0d), %0d characters checked",
                 words_sent, op_count[b2da_pkg::OP_U8], op_count[b2da_pkg::OP_U16],
                 op_count[b2da_pkg::OP_S16], op_count[b2da_pkg::OP_U32], chars_checked);
        $display("included a back-to-back stretch and %0d long receiver hold-off(s)",
                 holds_done);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### sim.f
hdl/b2da_pkg.sv
hdl/b2da_dabble.sv
hdl/binary_to_decimal_ascii.sv
tb/tb_top.sv
